@@ rtl/core/mailbox_table_engine_defines.svh @@
// assertion macros shared by the mailbox table engine modules
`ifndef MAILBOX_TABLE_ENGINE_DEFINES_SVH
`define MAILBOX_TABLE_ENGINE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define MTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mailbox table engine check failed");
// next-cycle implication, checked outside reset
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mailbox table engine check failed");
`else
`define MTE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/mte_pkg.sv @@
// shared types, codes and defaults of the mailbox table engine
package mte_pkg;

    // default sizes
    localparam int NUM_BOXES_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 3;
    localparam int MAX_LENGTH_DEF  = 256;

    // fixed field widths
    localparam int FUNC_W    = 2;
    localparam int ID_W      = 10;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 12;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 88;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEND     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RECEIVE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UNKNOWN  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    // command class decided by the front
    typedef enum logic [2:0] {
        KIND_NOMATCH = 3'd0,
        KIND_FAIL    = 3'd1,
        KIND_REG     = 3'd2,
        KIND_SEND    = 3'd3,
        KIND_RECV    = 3'd4
    } t_kind;

    // classified command handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    box_id;
        logic               want_queue;
        logic [WORD_W-1:0]  payload;
    } t_cmd;

endpackage

@@ rtl/core/mte_ram.sv @@
// generic single-write, single-read ram with registered read data
module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mte_front.sv @@
// command intake: accepts transactions, classifies them and queues them for the back end
`include "mailbox_table_engine_defines.svh"
module mte_front #(
    parameter int NUM_BOXES  = mte_pkg::NUM_BOXES_DEF,
    parameter int MAX_LENGTH = mte_pkg::MAX_LENGTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [mte_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [mte_pkg::FUNC_W-1:0]   s_axis_tuser,
    input  logic                         i_clear_done,
    output logic                         o_cmd_valid,
    output mte_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_pop
);

    localparam logic [31:0] BOX_LIMIT = 32'(NUM_BOXES);
    localparam logic [31:0] LEN_LIMIT = 32'(MAX_LENGTH);
    localparam int          CNT_W     = $clog2(mte_pkg::CMDQ_DEPTH + 1);
    localparam int          PTR_W     = $clog2(mte_pkg::CMDQ_DEPTH);

    logic [mte_pkg::ID_W-1:0]   w_box_id;
    logic                       w_want_queue;
    logic [mte_pkg::WORD_W-1:0] w_payload;
    logic [mte_pkg::LEN_W-1:0]  w_length;
    logic                       w_out_of_range;
    logic                       w_too_long;
    mte_pkg::t_cmd              w_cmd;
    logic                       w_push;

    mte_pkg::t_cmd              r_q [mte_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           n_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [PTR_W-1:0]           n_rd_ptr;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;

    // unpack the transaction fields
    assign w_box_id     = s_axis_tdata[9:0];
    assign w_want_queue = s_axis_tdata[10];
    assign w_payload    = s_axis_tdata[74:11];
    assign w_length     = s_axis_tdata[86:75];

    assign w_out_of_range = 32'(w_box_id) >= BOX_LIMIT;
    assign w_too_long     = 32'(w_length) > LEN_LIMIT;

    // classify the command
    always_comb begin
        w_cmd.box_id     = w_box_id;
        w_cmd.want_queue = w_want_queue;
        w_cmd.payload    = w_payload;
        case (s_axis_tuser)
            mte_pkg::FN_REGISTER: begin
                w_cmd.kind = w_out_of_range ? mte_pkg::KIND_FAIL : mte_pkg::KIND_REG;
            end
            mte_pkg::FN_SEND: begin
                w_cmd.kind = (w_out_of_range || w_too_long) ? mte_pkg::KIND_FAIL
                                                            : mte_pkg::KIND_SEND;
            end
            mte_pkg::FN_RECEIVE: begin
                w_cmd.kind = w_out_of_range ? mte_pkg::KIND_FAIL : mte_pkg::KIND_RECV;
            end
            default: begin
                w_cmd.kind = mte_pkg::KIND_NOMATCH;
            end
        endcase
    end

    // queue control
    assign s_axis_tready = i_clear_done && (r_count != CNT_W'(mte_pkg::CMDQ_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = r_count != '0;
    assign o_cmd         = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(mte_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(mte_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // checks
    `MTE_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(mte_pkg::CMDQ_DEPTH))
    `MTE_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_cmd_pop, r_count != '0)

endmodule

@@ rtl/core/mte_back.sv @@
// command execution: mailbox metadata and slot rams, sequencer and result register
`include "mailbox_table_engine_defines.svh"
module mte_back #(
    parameter int NUM_BOXES   = mte_pkg::NUM_BOXES_DEF,
    parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  mte_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_clear_done,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mte_pkg::WORD_W-1:0]     m_axis_tdata,
    output logic [mte_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int BOX_AW     = $clog2(NUM_BOXES);
    localparam int SLOT_DEPTH = NUM_BOXES * QUEUE_DEPTH;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int HEAD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W      = CNT_W + 1;
    localparam int META_W     = 2 + CNT_W + HEAD_W;

    // per-box bookkeeping
    typedef struct packed {
        logic              is_reg;
        logic              queued;
        logic [CNT_W-1:0]  count;
        logic [HEAD_W-1:0] head;
    } t_meta;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    mte_pkg::t_cmd                 r_cmd;
    logic [BOX_AW-1:0]             r_idx;
    logic [SLOT_AW-1:0]            r_base;
    logic [BOX_AW-1:0]             r_clr_idx;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [mte_pkg::STATUS_W-1:0]  r_out_status;
    logic [mte_pkg::STATUS_W-1:0]  n_out_status;
    logic [mte_pkg::WORD_W-1:0]    r_out_word;
    logic [mte_pkg::WORD_W-1:0]    n_out_word;

    logic [31:0]                   w_id_ext;
    logic [BOX_AW-1:0]             w_in_idx;
    logic                          w_out_free;
    t_meta                         w_meta;
    logic [META_W-1:0]             w_meta_rdata;
    logic                          w_meta_we;
    logic [BOX_AW-1:0]             w_meta_waddr;
    t_meta                         w_meta_wdata;
    logic                          w_slot_we;
    logic [SLOT_AW-1:0]            w_slot_addr;
    logic [mte_pkg::WORD_W-1:0]    w_slot_rdata;
    logic [SUM_W-1:0]              w_sum;
    logic [HEAD_W-1:0]             w_tail;
    logic [HEAD_W-1:0]             w_head_next;
    logic [HEAD_W-1:0]             w_offset;

    assign w_id_ext   = 32'(i_cmd.box_id);
    assign w_in_idx   = w_id_ext[BOX_AW-1:0];
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign o_clear_done = r_state != S_CLEAR;
    assign w_meta     = t_meta'(w_meta_rdata);

    // metadata ram, read for the command at the queue head
    mte_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_BOXES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (META_W'(w_meta_wdata)),
        .i_raddr (w_in_idx),
        .o_rdata (w_meta_rdata)
    );

    // message slot ram
    mte_ram #(
        .WIDTH (mte_pkg::WORD_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_addr),
        .i_wdata (r_cmd.payload),
        .i_raddr (w_slot_addr),
        .o_rdata (w_slot_rdata)
    );

    // fifo positions: tail and next head, one wrap each
    assign w_sum  = SUM_W'(w_meta.head) + SUM_W'(w_meta.count);
    assign w_tail = (w_sum >= SUM_W'(QUEUE_DEPTH)) ? HEAD_W'(w_sum - SUM_W'(QUEUE_DEPTH))
                                                    : HEAD_W'(w_sum);
    assign w_head_next = (SUM_W'(w_meta.head) + SUM_W'(1) >= SUM_W'(QUEUE_DEPTH)) ? '0
                       : w_meta.head + HEAD_W'(1);
    assign w_slot_addr = r_base + SLOT_AW'(w_offset);

    // command execution and sequencing
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_word   = r_out_word;
        w_meta_we    = 1'b0;
        w_meta_waddr = r_idx;
        w_meta_wdata = w_meta;
        w_slot_we    = 1'b0;
        w_offset     = '0;
        case (r_state)
            S_CLEAR: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_clr_idx;
                w_meta_wdata = '0;
                if (r_clr_idx == BOX_AW'(NUM_BOXES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_status = mte_pkg::ST_FAIL;
                n_out_word   = '0;
                case (r_cmd.kind)
                    mte_pkg::KIND_NOMATCH: begin
                        n_out_status = mte_pkg::ST_NOMATCH;
                    end
                    mte_pkg::KIND_REG: begin
                        if (!w_meta.is_reg) begin
                            w_meta_we           = 1'b1;
                            w_meta_wdata.is_reg = 1'b1;
                            w_meta_wdata.queued = r_cmd.want_queue;
                            w_meta_wdata.count  = '0;
                            w_meta_wdata.head   = '0;
                            n_out_status        = mte_pkg::ST_OK;
                        end
                    end
                    mte_pkg::KIND_SEND: begin
                        if (w_meta.is_reg && !w_meta.queued) begin
                            w_slot_we          = 1'b1;
                            w_meta_we          = 1'b1;
                            w_meta_wdata.count = CNT_W'(1);
                            n_out_status       = mte_pkg::ST_OK;
                        end else if (w_meta.is_reg
                                     && (w_meta.count < CNT_W'(QUEUE_DEPTH))) begin
                            w_offset           = w_tail;
                            w_slot_we          = 1'b1;
                            w_meta_we          = 1'b1;
                            w_meta_wdata.count = w_meta.count + CNT_W'(1);
                            n_out_status       = mte_pkg::ST_OK;
                        end
                    end
                    mte_pkg::KIND_RECV: begin
                        if (w_meta.is_reg && (w_meta.count != '0)) begin
                            // result waits in S_READ for the registered slot read
                            n_out_valid = 1'b0;
                            n_state     = S_READ;
                            if (w_meta.queued) begin
                                w_offset           = w_meta.head;
                                w_meta_we          = 1'b1;
                                w_meta_wdata.head  = w_head_next;
                                w_meta_wdata.count = w_meta.count - CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                        n_out_status = mte_pkg::ST_FAIL;
                    end
                endcase
            end
            S_READ: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_status = mte_pkg::ST_OK;
                n_out_word   = w_slot_rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_word   <= n_out_word;
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_idx  <= w_in_idx;
            r_base <= SLOT_AW'(w_in_idx) * SLOT_AW'(QUEUE_DEPTH);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_status;

    // checks
    `MTE_ASSERT_NOW(a_exec_out_free, i_clk, i_rst_n, r_state == S_EXEC, !r_out_valid)
    `MTE_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, r_state == S_READ, r_out_valid)
    `MTE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_state == S_EXEC, w_meta.count <= CNT_W'(QUEUE_DEPTH))

endmodule

@@ rtl/core/mailbox_table_engine.sv @@
// mailbox table engine: register, send and receive commands on a table of mailboxes
//
// commands arrive on the s_axis channel: tuser carries the command code, tdata the
// box number, queue flag, message word and message length. every command yields one
// result on m_axis: tuser carries the status, tdata the received word (zero unless a
// receive succeeds). results come back in command order.
// a command is popped in S_IDLE once the result register is free; the metadata ram read
// of the addressed box then feeds S_EXEC, which writes the metadata back and registers
// the result. a successful receive also passes through S_READ for the slot ram read.
// the back end finishes one command before it takes the next.
// a two-entry command queue takes new transactions while the back end works or the
// result register waits. when the receiver stalls the result is held; once the queue
// fills s_axis_tready drops.
// after reset a clearing pass writes zero into the metadata of each mailbox in turn;
// s_axis_tready stays low until it finishes. message slots are not cleared.
module mailbox_table_engine #(
    parameter int NUM_BOXES   = mte_pkg::NUM_BOXES_DEF,
    parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_LENGTH  = mte_pkg::MAX_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // box_id[9:0], want_queue[10], payload[74:11], payload_length[86:75], zero[87]
    input  logic [mte_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [mte_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_word[63:0]
    output logic [mte_pkg::WORD_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [mte_pkg::STATUS_W-1:0]   m_axis_tuser
);

    logic          w_cmd_valid;
    mte_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;
    logic          w_clear_done;

    mte_front #(
        .NUM_BOXES  (NUM_BOXES),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_clear_done  (w_clear_done),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    mte_back #(
        .NUM_BOXES   (NUM_BOXES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_clear_done  (w_clear_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ tb/tb_mailbox_table_engine.sv @@
// testbench for the mailbox table engine: directed and random command streams, checked in order
`timescale 1ns / 1ps

module tb_mailbox_table_engine;

    localparam int NUM_BOXES      = mte_pkg::NUM_BOXES_DEF;
    localparam int QUEUE_DEPTH    = mte_pkg::QUEUE_DEPTH_DEF;
    localparam int MAX_LENGTH     = mte_pkg::MAX_LENGTH_DEF;
    localparam int HOT_BOXES      = 12;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam time RUN_LIMIT     = 2_000_000;

    // one command as the sender sees it
    typedef struct packed {
        logic [mte_pkg::FUNC_W-1:0]   func;
        logic [mte_pkg::ID_W-1:0]     box_id;
        logic                         want_queue;
        logic [mte_pkg::WORD_W-1:0]   payload;
        logic [mte_pkg::LEN_W-1:0]    msg_len;
    } t_box_cmd;

    // one result as the receiver sees it
    typedef struct packed {
        logic [mte_pkg::STATUS_W-1:0] status;
        logic [mte_pkg::WORD_W-1:0]   read_word;
    } t_box_reply;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // box_id[9:0], want_queue[10], payload[74:11], payload_length[86:75], zero[87]
    logic [mte_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    // func[1:0]
    logic [mte_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // read_word[63:0]
    logic [mte_pkg::WORD_W-1:0]      m_axis_tdata;
    // status[1:0]
    logic [mte_pkg::STATUS_W-1:0]    m_axis_tuser;

    // shadow copy of the mailbox table
    bit                              tbl_registered [NUM_BOXES];
    bit                              tbl_queued [NUM_BOXES];
    bit [1:0]                        tbl_count [NUM_BOXES];
    bit [1:0]                        tbl_head [NUM_BOXES];
    logic [mte_pkg::WORD_W-1:0]      tbl_slots [NUM_BOXES*QUEUE_DEPTH];

    t_box_reply             box_replies_due [$];
    int unsigned            hot_boxes [HOT_BOXES];
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    logic                   hold_rx = 1'b0;
    int                     error_count = 0;
    int                     cmds_sent = 0;
    int                     replies_checked = 0;
    int                     words_returned = 0;
    int                     refusals = 0;

    mailbox_table_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // apply one command to the shadow table and return the result it should give
    function automatic t_box_reply box_table_apply(input t_box_cmd c);
        t_box_reply  r;
        int unsigned base;
        int unsigned pos;
        r.status    = mte_pkg::ST_OK;
        r.read_word = '0;
        base = int'(c.box_id) * QUEUE_DEPTH;
        if (c.func == mte_pkg::FN_UNKNOWN) begin
            r.status = mte_pkg::ST_NOMATCH;
        end else if (int'(c.box_id) >= NUM_BOXES) begin
            r.status = mte_pkg::ST_FAIL;
        end else begin
            case (c.func)
                mte_pkg::FN_REGISTER: begin
                    if (tbl_registered[c.box_id]) begin
                        r.status = mte_pkg::ST_FAIL;
                    end else begin
                        tbl_registered[c.box_id] = 1'b1;
                        tbl_queued[c.box_id]     = c.want_queue;
                        tbl_count[c.box_id]      = '0;
                        tbl_head[c.box_id]       = '0;
                    end
                end
                mte_pkg::FN_SEND: begin
                    // length is checked before the box is looked at
                    if (int'(c.msg_len) > MAX_LENGTH || !tbl_registered[c.box_id]) begin
                        r.status = mte_pkg::ST_FAIL;
                    end else if (!tbl_queued[c.box_id]) begin
                        tbl_slots[base]     = c.payload;
                        tbl_count[c.box_id] = 2'd1;
                    end else if (int'(tbl_count[c.box_id]) >= QUEUE_DEPTH) begin
                        r.status = mte_pkg::ST_FAIL;
                    end else begin
                        // tail sits count places past the head, wrapping round
                        pos = base + (int'(tbl_head[c.box_id]) + int'(tbl_count[c.box_id]))
                              % QUEUE_DEPTH;
                        tbl_slots[pos]      = c.payload;
                        tbl_count[c.box_id] = tbl_count[c.box_id] + 2'd1;
                    end
                end
                default: begin
                    if (!tbl_registered[c.box_id] || tbl_count[c.box_id] == 0) begin
                        r.status = mte_pkg::ST_FAIL;
                    end else if (!tbl_queued[c.box_id]) begin
                        // unqueued read leaves the word in place
                        r.read_word = tbl_slots[base];
                    end else begin
                        r.read_word = tbl_slots[base + int'(tbl_head[c.box_id])];
                        tbl_head[c.box_id]  = 2'((int'(tbl_head[c.box_id]) + 1) % QUEUE_DEPTH);
                        tbl_count[c.box_id] = tbl_count[c.box_id] - 2'd1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_box_cmd make_cmd(input logic [mte_pkg::FUNC_W-1:0] func,
                                          input int unsigned id, input logic q,
                                          input logic [mte_pkg::WORD_W-1:0] word,
                                          input int unsigned len);
        t_box_cmd c;
        c.func       = func;
        c.box_id     = mte_pkg::ID_W'(id);
        c.want_queue = q;
        c.payload    = word;
        c.msg_len    = mte_pkg::LEN_W'(len);
        return c;
    endfunction

    // mostly commands on a few hot boxes with legal lengths, some noise across the table
    function automatic t_box_cmd random_command();
        int unsigned pick;
        int unsigned id;
        int unsigned len;
        logic [mte_pkg::FUNC_W-1:0] func;
        pick = $urandom_range(99);
        if (pick < 12)
            func = mte_pkg::FN_REGISTER;
        else if (pick < 55)
            func = mte_pkg::FN_SEND;
        else if (pick < 93)
            func = mte_pkg::FN_RECEIVE;
        else
            func = mte_pkg::FN_UNKNOWN;
        if ($urandom_range(99) < 75)
            id = hot_boxes[$urandom_range(HOT_BOXES-1)];
        else
            id = $urandom_range(NUM_BOXES-1);
        if ($urandom_range(99) < 85)
            len = $urandom_range(MAX_LENGTH);
        else
            len = $urandom_range((1 << mte_pkg::LEN_W) - 1);
        return make_cmd(func, id, 1'($urandom), {$urandom, $urandom}, len);
    endfunction

    // offer one command and wait for its transaction
    task automatic send_command(input t_box_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.func;
        s_axis_tdata  <= {1'b0, c.msg_len, c.payload, c.want_queue, c.box_id};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        box_replies_due.push_back(box_table_apply(c));
        cmds_sent++;
    endtask

    // receiver readiness, forced low during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : reply_check
        t_box_reply due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (box_replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d word %h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                due = box_replies_due.pop_front();
                replies_checked++;
                if (due.status == mte_pkg::ST_FAIL)
                    refusals++;
                if (due.status == mte_pkg::ST_OK && due.read_word != '0)
                    words_returned++;
                if (m_axis_tuser !== due.status)
                    report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                              replies_checked, m_axis_tuser, due.status));
                if (m_axis_tdata !== due.read_word)
                    report_mismatch($sformatf("result %0d word %h, wanted %h",
                                              replies_checked, m_axis_tdata, due.read_word));
            end
        end
    end

    // extremes of every field and each refusal case
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_command(make_cmd(mte_pkg::FN_UNKNOWN, NUM_BOXES-1, 1'b1, '1,
                              (1 << mte_pkg::LEN_W) - 1));
        send_command(make_cmd(mte_pkg::FN_SEND, NUM_BOXES-1, 1'b0, 64'h0123_4567_89ab_cdef, 4));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, 0, 1'b0, '0, 0));
        // unqueued box: overwrite slot, non-destructive read
        send_command(make_cmd(mte_pkg::FN_REGISTER, 0, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_REGISTER, 0, 1'b1, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, 0, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_SEND, 0, 1'b0, '1, MAX_LENGTH));
        send_command(make_cmd(mte_pkg::FN_SEND, 0, 1'b0, 64'h5555_aaaa_5555_aaaa,
                              MAX_LENGTH + 1));
        send_command(make_cmd(mte_pkg::FN_SEND, 0, 1'b0, 64'haaaa_5555_aaaa_5555,
                              (1 << mte_pkg::LEN_W) - 1));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, 0, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, 0, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_SEND, 0, 1'b1, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, 0, 1'b0, '0, 0));
        // queued box: fill past full, drain past empty
        send_command(make_cmd(mte_pkg::FN_REGISTER, NUM_BOXES-1, 1'b1, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, NUM_BOXES-1, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_SEND, NUM_BOXES-1, 1'b0, 64'h1111_0000_0000_0001, 1));
        send_command(make_cmd(mte_pkg::FN_SEND, NUM_BOXES-1, 1'b0, 64'h2222_0000_0000_0002, 2));
        send_command(make_cmd(mte_pkg::FN_SEND, NUM_BOXES-1, 1'b0, 64'h3333_0000_0000_0003, 3));
        send_command(make_cmd(mte_pkg::FN_SEND, NUM_BOXES-1, 1'b0, 64'h4444_0000_0000_0004, 4));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, NUM_BOXES-1, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, NUM_BOXES-1, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, NUM_BOXES-1, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_RECEIVE, NUM_BOXES-1, 1'b0, '0, 0));
        send_command(make_cmd(mte_pkg::FN_UNKNOWN, 0, 1'b0, '0, 0));
    endtask

    // random stream on a fresh set of hot boxes
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        foreach (hot_boxes[i])
            hot_boxes[i] = $urandom_range(NUM_BOXES-1);
        repeat (count)
            send_command(random_command());
    endtask

    // receiver stalls for a long stretch while commands keep coming
    task automatic test_receiver_hold();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (16)
            send_command(random_command());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(340, 13, 86);
        test_random_traffic(340, 86, 13);
        test_random_traffic(340, 0, 0);
        test_receiver_hold();
        s_axis_tvalid <= 1'b0;

        // let the last results come out, then watch for strays
        while (box_replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d commands sent, %0d results checked", cmds_sent, replies_checked);
        $display("run: %0d receives returned a non-zero word, %0d commands refused",
                 words_returned, refusals);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
